// File: src/strint_pkg.sv
// Shared types and constants for the string-to-integer parser.
package strint_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int CHAR_WIDTH          = 8;
    localparam int RESULT_WIDTH        = 32;

    // Parser phase, one-hot
    typedef enum logic [3:0] {
        PH_START = 4'b0001,
        PH_ZERO  = 4'b0010,
        PH_DIGIT = 4'b0100,
        PH_DONE  = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_BIN = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_HEX = 2'd3
    } radix_t;

    // Control part of the parser state
    typedef struct packed {
        phase_t phase;
        radix_t radix;
        logic   neg;
    } ctrl_t;

    localparam ctrl_t CTRL_RESET = '{phase: PH_START, radix: RADIX_DEC, neg: 1'b0};

    // ASCII codes
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS      = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS       = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CHAR_DIGIT_0    = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_DIGIT_1    = 8'h31;
    localparam logic [CHAR_WIDTH-1:0] CHAR_DIGIT_9    = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_B    = 8'h42;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_F    = 8'h46;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_X    = 8'h58;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_B    = 8'h62;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_F    = 8'h66;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_X    = 8'h78;

endpackage

// File: src/strint_step.sv
// Next-state logic of the parser for one character.
module strint_step #(
    parameter int VALUE_WIDTH = strint_pkg::DEFAULT_VALUE_WIDTH
) (
    input  strint_pkg::ctrl_t                    ctrl_i,
    input  logic [VALUE_WIDTH-1:0]               acc_i,
    input  logic [strint_pkg::CHAR_WIDTH-1:0]    char_i,
    input  logic                                 none_i,
    output strint_pkg::ctrl_t                    ctrl_o,
    output logic [VALUE_WIDTH-1:0]               acc_o
);

    logic                   hit;
    logic [3:0]             digit_val;
    logic                   in_radix;
    logic                   is_digit;
    strint_pkg::radix_t     eff_radix;
    logic [VALUE_WIDTH-1:0] scaled;
    logic [VALUE_WIDTH-1:0] digit_ext;
    logic [VALUE_WIDTH-1:0] digit_signed;
    logic [VALUE_WIDTH-1:0] acc_digit;

    // Decode the character as a hex digit
    always_comb begin
        hit       = 1'b0;
        digit_val = 4'd0;
        if (char_i >= strint_pkg::CHAR_DIGIT_0 && char_i <= strint_pkg::CHAR_DIGIT_9) begin
            hit       = 1'b1;
            digit_val = 4'(char_i - strint_pkg::CHAR_DIGIT_0);
        end else if (char_i >= strint_pkg::CHAR_LOWER_A
                     && char_i <= strint_pkg::CHAR_LOWER_F) begin
            hit       = 1'b1;
            digit_val = 4'(char_i - strint_pkg::CHAR_LOWER_A) + 4'd10;
        end else if (char_i >= strint_pkg::CHAR_UPPER_A
                     && char_i <= strint_pkg::CHAR_UPPER_F) begin
            hit       = 1'b1;
            digit_val = 4'(char_i - strint_pkg::CHAR_UPPER_A) + 4'd10;
        end
    end

    // After a leading zero the next character is read as octal
    assign eff_radix = (ctrl_i.phase == strint_pkg::PH_ZERO) ? strint_pkg::RADIX_OCT
                                                              : ctrl_i.radix;

    // Range check and shift for the radix in use
    always_comb begin
        unique case (eff_radix)
            strint_pkg::RADIX_BIN: begin
                in_radix = (digit_val < 4'd2);
                scaled   = acc_i << 1;
            end
            strint_pkg::RADIX_OCT: begin
                in_radix = (digit_val < 4'd8);
                scaled   = acc_i << 3;
            end
            strint_pkg::RADIX_DEC: begin
                in_radix = (digit_val < 4'd10);
                scaled   = (acc_i << 3) + (acc_i << 1);
            end
            default: begin
                in_radix = 1'b1;
                scaled   = acc_i << 4;
            end
        endcase
    end

    // A negative number accumulates downward so no final negate is needed
    assign is_digit     = hit && in_radix;
    assign digit_ext    = {{(VALUE_WIDTH-4){1'b0}}, digit_val};
    assign digit_signed = ctrl_i.neg ? ('0 - digit_ext) : digit_ext;
    assign acc_digit    = scaled + digit_signed;

    // Advance the parse by one character
    always_comb begin
        ctrl_o = ctrl_i;
        acc_o  = acc_i;
        if (!none_i) begin
            unique case (ctrl_i.phase)
                strint_pkg::PH_START: begin
                    priority if (char_i == strint_pkg::CHAR_MINUS) begin
                        ctrl_o.neg   = 1'b1;
                        ctrl_o.radix = strint_pkg::RADIX_DEC;
                        ctrl_o.phase = strint_pkg::PH_DIGIT;
                    end else if (char_i == strint_pkg::CHAR_PLUS) begin
                        ctrl_o.radix = strint_pkg::RADIX_DEC;
                        ctrl_o.phase = strint_pkg::PH_DIGIT;
                    end else if (char_i == strint_pkg::CHAR_DIGIT_0) begin
                        ctrl_o.phase = strint_pkg::PH_ZERO;
                    end else if (char_i >= strint_pkg::CHAR_DIGIT_1
                                 && char_i <= strint_pkg::CHAR_DIGIT_9) begin
                        acc_o        = digit_ext;
                        ctrl_o.radix = strint_pkg::RADIX_DEC;
                        ctrl_o.phase = strint_pkg::PH_DIGIT;
                    end else begin
                        acc_o        = '0;
                        ctrl_o.neg   = 1'b0;
                        ctrl_o.phase = strint_pkg::PH_DONE;
                    end
                end
                strint_pkg::PH_ZERO: begin
                    ctrl_o.phase = strint_pkg::PH_DIGIT;
                    priority if (char_i == strint_pkg::CHAR_LOWER_B
                                 || char_i == strint_pkg::CHAR_UPPER_B) begin
                        ctrl_o.radix = strint_pkg::RADIX_BIN;
                    end else if (char_i == strint_pkg::CHAR_LOWER_X
                                 || char_i == strint_pkg::CHAR_UPPER_X) begin
                        ctrl_o.radix = strint_pkg::RADIX_HEX;
                    end else begin
                        ctrl_o.radix = strint_pkg::RADIX_OCT;
                        if (is_digit) begin
                            acc_o = acc_digit;
                        end else if (char_i != strint_pkg::CHAR_UNDERSCORE) begin
                            ctrl_o.phase = strint_pkg::PH_DONE;
                        end
                    end
                end
                strint_pkg::PH_DIGIT: begin
                    if (is_digit) begin
                        acc_o = acc_digit;
                    end else if (char_i != strint_pkg::CHAR_UNDERSCORE) begin
                        ctrl_o.phase = strint_pkg::PH_DONE;
                    end
                end
                default: begin
                    // Parse finished: ignore the rest of the string
                end
            endcase
        end
    end

endmodule

// File: src/strint_out.sv
// Result register of the parser, master side of the output stream.
module strint_out (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load_i,
    input  logic [strint_pkg::RESULT_WIDTH-1:0] data_i,
    output logic                                space_o,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [strint_pkg::RESULT_WIDTH-1:0] m_tdata    // [31:0] value
);

    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [strint_pkg::RESULT_WIDTH-1:0] out_data_reg;

    // Free when empty or when the held beat leaves this cycle
    assign space_o = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_i) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (load_i) begin
            out_data_reg <= data_i;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: src/string_to_integer_parser_top.sv
// Top level of the string-to-integer parser with sign and radix prefix.
//
//   channel | direction | tdata           | tlast     | tuser
//   s_      | in        | [7:0] char_code | last_char | no_char
//   m_      | out       | [31:0] value    | -         | -
//
// One character beat is taken per cycle unless a last beat waits on a stalled
// result; the only loop is the parser state updated by one shift-add per character,
// so beats may follow back to back. m_tvalid rises once the beat marked last has
// moved from the input register into the result register.
// Reset clears the input and result valid flags and the parser state.
// A stalled result holds a later last beat in the input register; beats before it keep flowing.
module string_to_integer_parser_top #(
    parameter int VALUE_WIDTH = strint_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [strint_pkg::CHAR_WIDTH-1:0]   s_tdata,   // [7:0] char_code
    input  logic                                s_tlast,
    input  logic                                s_tuser,   // [0] no_char
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [strint_pkg::RESULT_WIDTH-1:0] m_tdata    // [31:0] value
);

    logic                                in_valid_reg;
    logic                                in_valid_next;
    logic [strint_pkg::CHAR_WIDTH-1:0]   in_char_reg;
    logic                                in_last_reg;
    logic                                in_none_reg;
    strint_pkg::ctrl_t                   ctrl_reg;
    strint_pkg::ctrl_t                   ctrl_next;
    logic [VALUE_WIDTH-1:0]              acc_reg;
    logic [VALUE_WIDTH-1:0]              acc_next;
    strint_pkg::ctrl_t                   step_ctrl;
    logic [VALUE_WIDTH-1:0]              step_acc;
    logic [strint_pkg::RESULT_WIDTH-1:0] result;
    logic                                out_space;
    logic                                advance;
    logic                                out_load;
    logic                                s_take;

    // Move the held beat on unless a result cannot be stored yet
    assign advance  = in_valid_reg && (!in_last_reg || out_space);
    assign out_load = advance && in_last_reg;
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Capture the input beat
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
            in_none_reg <= s_tuser;
        end
    end

    strint_step #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_step (
        .ctrl_i (ctrl_reg),
        .acc_i  (acc_reg),
        .char_i (in_char_reg),
        .none_i (in_none_reg),
        .ctrl_o (step_ctrl),
        .acc_o  (step_acc)
    );

    // Return to the start of a string after a last beat
    always_comb begin
        ctrl_next = ctrl_reg;
        acc_next  = acc_reg;
        if (advance) begin
            if (in_last_reg) begin
                ctrl_next = strint_pkg::CTRL_RESET;
                acc_next  = '0;
            end else begin
                ctrl_next = step_ctrl;
                acc_next  = step_acc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= strint_pkg::CTRL_RESET;
            acc_reg  <= '0;
        end else begin
            ctrl_reg <= ctrl_next;
            acc_reg  <= acc_next;
        end
    end

    // Sign-extend or truncate the accumulator to the result width
    generate
        if (VALUE_WIDTH >= strint_pkg::RESULT_WIDTH) begin : g_trunc
            assign result = step_acc[strint_pkg::RESULT_WIDTH-1:0];
        end else begin : g_extend
            assign result = {{(strint_pkg::RESULT_WIDTH-VALUE_WIDTH){step_acc[VALUE_WIDTH-1]}},
                             step_acc};
        end
    endgenerate

    strint_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_i   (out_load),
        .data_i   (result),
        .space_o  (out_space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A result is produced only from a held last beat
    a_load_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (in_valid_reg && in_last_reg))
        else $error("result loaded without a last beat");

    // The parser is back at the start after a string ends
    a_reset_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (ctrl_reg == strint_pkg::CTRL_RESET && acc_reg == '0))
        else $error("parser state not cleared after a string");

    // Once done, the value does not change until the string ends
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_reg.phase == strint_pkg::PH_DONE && !out_load)
        |=> ($stable(acc_reg) && ctrl_reg.phase == strint_pkg::PH_DONE))
        else $error("accumulator changed after the parse ended");

    // A minus sign only exists once digits are expected
    a_neg_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_reg.neg |-> (ctrl_reg.phase == strint_pkg::PH_DIGIT
                          || ctrl_reg.phase == strint_pkg::PH_DONE))
        else $error("negative flag set outside the digit phases");

endmodule
